### design/tpja_pkg.sv
// Shared constants, types and the arctangent table for the joint angle pipeline.
package tpja_pkg;

    localparam int COORD_WIDTH_DEF = 14;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int TAG_WIDTH       = 4;

    // the largest normalized magnitude sits in [2^29, 2^30), the others below 2^30
    localparam int NORM_W       = 30;
    localparam int NORM_TOP     = NORM_W - 1;
    localparam int RAD_W        = 2 * NORM_W + 2;
    localparam int ROOT_W       = NORM_W + 1;
    localparam int CORDIC_STEPS = 28;
    localparam int XY_W         = 35;
    localparam int Z_W          = 33;
    localparam int ATAN_W       = 31;

    typedef struct packed {
        logic                 valid;
        logic                 zero;   // cross and dot both zero
        logic                 neg;    // dot product negative
        logic                 coll;   // root is zero
        logic                 perp;   // scaled dot is zero
        logic [TAG_WIDTH-1:0] tag;
    } tpja_side_t;

    // atan(2^-i) in units of pi/2^31
    function automatic logic [ATAN_W-1:0] atan_entry(input int idx);
        logic [ATAN_W-1:0] val;
        unique case (idx)
            0:       val = 31'd536870912;
            1:       val = 31'd316933406;
            2:       val = 31'd167458907;
            3:       val = 31'd85004756;
            4:       val = 31'd42667331;
            5:       val = 31'd21354465;
            6:       val = 31'd10679838;
            7:       val = 31'd5340245;
            8:       val = 31'd2670163;
            9:       val = 31'd1335087;
            10:      val = 31'd667544;
            11:      val = 31'd333772;
            12:      val = 31'd166886;
            13:      val = 31'd83443;
            14:      val = 31'd41722;
            15:      val = 31'd20861;
            16:      val = 31'd10430;
            17:      val = 31'd5215;
            18:      val = 31'd2608;
            19:      val = 31'd1304;
            20:      val = 31'd652;
            21:      val = 31'd326;
            22:      val = 31'd163;
            23:      val = 31'd81;
            24:      val = 31'd41;
            25:      val = 31'd20;
            26:      val = 31'd10;
            27:      val = 31'd5;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### design/tpja_front.sv
// Front pipeline: segment vectors, cross and dot products, scaling and sum of squares.
module tpja_front #(
    parameter int COORD_WIDTH = tpja_pkg::COORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic signed [COORD_WIDTH-1:0]   pos [9],
    input  tpja_pkg::tpja_side_t            side_in,
    output logic [tpja_pkg::RAD_W-1:0]      rad,
    output logic [tpja_pkg::NORM_W-1:0]     dmag,
    output tpja_pkg::tpja_side_t            side_out
);
    import tpja_pkg::*;

    localparam int DW     = COORD_WIDTH + 1;
    localparam int PW     = 2 * DW;
    localparam int SW     = 2 * COORD_WIDTH + 3;
    localparam int MW     = 2 * COORD_WIDTH + 2;
    localparam int NCH    = (MW + 7) / 8;
    localparam int CHW    = NCH * 8;
    localparam int PBW    = $clog2(MW);
    localparam int EXW    = MW + NORM_TOP;
    localparam int NSTAGE = 11;

    logic signed [DW-1:0] ext [9];
    logic signed [DW-1:0] a_reg [3];
    logic signed [DW-1:0] b_reg [3];
    logic signed [PW-1:0] prod_reg [9];
    logic signed [SW-1:0] sum_reg [4];
    logic [MW-1:0]        mag_reg [5][4];
    logic [MW-1:0]        pmax_reg [2];
    logic [MW-1:0]        m_reg;
    logic [NCH-1:0]       nz_reg;
    logic [2:0]           cpos_reg [NCH];
    logic [PBW-1:0]       p_reg;
    logic [NORM_W-1:0]    norm_reg [4];
    logic [2*NORM_W-1:0]  sq_reg [3];
    logic [NORM_W-1:0]    nd10_reg;
    logic [RAD_W-1:0]     rad_reg;
    logic [NORM_W-1:0]    nd11_reg;

    logic [MW-1:0]        mag_next [4];
    logic [CHW-1:0]       mpad;
    logic [NCH-1:0]       nz_next;
    logic [2:0]           cpos_next [NCH];
    logic [PBW-1:0]       p_next;
    logic [EXW-1:0]       shifted [4];

    tpja_side_t side_reg [NSTAGE];
    tpja_side_t side_next [NSTAGE];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            ext[k] = {pos[k][COORD_WIDTH-1], pos[k]};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            mag_next[k] = sum_reg[k][SW-1] ? MW'(-sum_reg[k]) : MW'(sum_reg[k]);
        end
    end

    // leading one: per byte first, then across bytes
    assign mpad = CHW'(m_reg);

    always_comb
    begin
        for (int k = 0; k < NCH; k++)
        begin
            nz_next[k]   = |mpad[k*8 +: 8];
            cpos_next[k] = '0;
            for (int b = 0; b < 8; b++)
            begin
                if (mpad[k*8 + b])
                begin
                    cpos_next[k] = 3'(b);
                end
            end
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int k = 0; k < NCH; k++)
        begin
            if (nz_reg[k])
            begin
                p_next = PBW'(k * 8) + PBW'(cpos_reg[k]);
            end
        end
    end

    // value * 2^(29 - p), truncating when p > 29
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            shifted[k] = {mag_reg[4][k], {NORM_TOP{1'b0}}} >> p_reg;
        end
    end

    always_comb
    begin
        side_next[0] = side_in;
        for (int s = 1; s < NSTAGE; s++)
        begin
            side_next[s] = side_reg[s-1];
        end
        side_next[3].neg  = sum_reg[3][SW-1];
        side_next[6].zero = (m_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTAGE; s++)
            begin
                side_reg[s] <= '0;
            end
        end
        else if (en)
        begin
            for (int s = 0; s < NSTAGE; s++)
            begin
                side_reg[s] <= side_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_reg[k] <= ext[k] - ext[k+3];
                b_reg[k] <= ext[k+3] - ext[k+6];
            end
            prod_reg[0] <= a_reg[1] * b_reg[2];
            prod_reg[1] <= a_reg[2] * b_reg[1];
            prod_reg[2] <= a_reg[2] * b_reg[0];
            prod_reg[3] <= a_reg[0] * b_reg[2];
            prod_reg[4] <= a_reg[0] * b_reg[1];
            prod_reg[5] <= a_reg[1] * b_reg[0];
            prod_reg[6] <= a_reg[0] * b_reg[0];
            prod_reg[7] <= a_reg[1] * b_reg[1];
            prod_reg[8] <= a_reg[2] * b_reg[2];
            sum_reg[0] <= SW'(prod_reg[0]) - SW'(prod_reg[1]);
            sum_reg[1] <= SW'(prod_reg[2]) - SW'(prod_reg[3]);
            sum_reg[2] <= SW'(prod_reg[4]) - SW'(prod_reg[5]);
            sum_reg[3] <= SW'(prod_reg[6]) + SW'(prod_reg[7]) + SW'(prod_reg[8]);
            for (int k = 0; k < 4; k++)
            begin
                mag_reg[0][k] <= mag_next[k];
                for (int s = 1; s < 5; s++)
                begin
                    mag_reg[s][k] <= mag_reg[s-1][k];
                end
            end
            pmax_reg[0] <= (mag_reg[0][1] > mag_reg[0][0]) ? mag_reg[0][1] : mag_reg[0][0];
            pmax_reg[1] <= (mag_reg[0][3] > mag_reg[0][2]) ? mag_reg[0][3] : mag_reg[0][2];
            m_reg       <= (pmax_reg[1] > pmax_reg[0]) ? pmax_reg[1] : pmax_reg[0];
            nz_reg      <= nz_next;
            for (int k = 0; k < NCH; k++)
            begin
                cpos_reg[k] <= cpos_next[k];
            end
            p_reg <= p_next;
            for (int k = 0; k < 4; k++)
            begin
                norm_reg[k] <= shifted[k][NORM_W-1:0];
            end
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= norm_reg[k] * norm_reg[k];
            end
            nd10_reg <= norm_reg[3];
            rad_reg  <= RAD_W'(sq_reg[0]) + RAD_W'(sq_reg[1]) + RAD_W'(sq_reg[2]);
            nd11_reg <= nd10_reg;
        end
    end

    assign rad      = rad_reg;
    assign dmag     = nd11_reg;
    assign side_out = side_reg[NSTAGE-1];

endmodule

### design/tpja_sqrt_cell.sv
// One cell of the square-root chain: decides one bit of the root.
module tpja_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  tpja_pkg::tpja_side_t          side_in,
    input  logic [tpja_pkg::RAD_W-1:0]    rem_in,
    input  logic [tpja_pkg::ROOT_W-1:0]   root_in,
    input  logic [tpja_pkg::NORM_W-1:0]   d_in,
    output tpja_pkg::tpja_side_t          side_out,
    output logic [tpja_pkg::RAD_W-1:0]    rem_out,
    output logic [tpja_pkg::ROOT_W-1:0]   root_out,
    output logic [tpja_pkg::NORM_W-1:0]   d_out
);
    import tpja_pkg::*;

    localparam int TW = RAD_W + 2;

    logic [TW-1:0]     trial;
    logic              fit;
    tpja_side_t        side_reg;
    logic [RAD_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [NORM_W-1:0] d_reg;

    // (q + 2^i)^2 - q^2 = q*2^(i+1) + 2^(2i)
    assign trial = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    assign fit   = TW'(rem_in) >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= fit ? rem_in - RAD_W'(trial) : rem_in;
            root_reg <= fit ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
            d_reg    <= d_in;
        end
    end

    assign side_out = side_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign d_out    = d_reg;

endmodule

### design/tpja_cordic_cell.sv
// One vectoring step of the arctangent chain.
module tpja_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  tpja_pkg::tpja_side_t              side_in,
    input  logic signed [tpja_pkg::XY_W-1:0]  x_in,
    input  logic signed [tpja_pkg::XY_W-1:0]  y_in,
    input  logic signed [tpja_pkg::Z_W-1:0]   z_in,
    output tpja_pkg::tpja_side_t              side_out,
    output logic signed [tpja_pkg::XY_W-1:0]  x_out,
    output logic signed [tpja_pkg::XY_W-1:0]  y_out,
    output logic signed [tpja_pkg::Z_W-1:0]   z_out
);
    import tpja_pkg::*;

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  za;
    tpja_side_t             side_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;

    assign xs = x_in >>> STEP;
    assign ys = y_in >>> STEP;
    assign za = Z_W'(atan_entry(STEP));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (y_in > 0)
            begin
                x_reg <= x_in + ys;
                y_reg <= y_in - xs;
                z_reg <= z_in + za;
            end
            else
            begin
                x_reg <= x_in - ys;
                y_reg <= y_in + xs;
                z_reg <= z_in - za;
            end
        end
    end

    assign side_out = side_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

endmodule

### design/three_point_joint_angle.sv
// Top level: interior angle at the vertex of three 3-D joint positions.
//
//   channel  signals                                     direction
//   input    in_valid, in_ready, outer_*, vertex_*,      in
//            inner_*, angle_tag
//   output   out_valid, out_ready, joint_angle,          out
//            result_tag
//
// One transaction per clock while in_ready is high. The path is 11 front
// stages, one square-root cell per root bit (31) and one CORDIC cell per
// step (28), then the output register. rst_n clears all valid flags. A
// stalled output fills a one-entry skid register; only then does in_ready
// drop and the whole chain hold.
module three_point_joint_angle #(
    parameter int COORD_WIDTH = tpja_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = tpja_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COORD_WIDTH-1:0]        outer_x,
    input  logic signed [COORD_WIDTH-1:0]        outer_y,
    input  logic signed [COORD_WIDTH-1:0]        outer_z,
    input  logic signed [COORD_WIDTH-1:0]        vertex_x,
    input  logic signed [COORD_WIDTH-1:0]        vertex_y,
    input  logic signed [COORD_WIDTH-1:0]        vertex_z,
    input  logic signed [COORD_WIDTH-1:0]        inner_x,
    input  logic signed [COORD_WIDTH-1:0]        inner_y,
    input  logic signed [COORD_WIDTH-1:0]        inner_z,
    input  logic [tpja_pkg::TAG_WIDTH-1:0]       angle_tag,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ANGLE_WIDTH-1:0]               joint_angle,
    output logic [tpja_pkg::TAG_WIDTH-1:0]       result_tag
);
    import tpja_pkg::*;

    localparam int               SH       = 32 - ANGLE_WIDTH;
    localparam int               ZC_W     = 31;
    localparam logic [ZC_W-1:0]  Z_MAX    = ZC_W'(1) << 30;
    localparam logic [ZC_W-1:0]  RND_HALF = ZC_W'(1) << (SH - 1);
    localparam logic [ANGLE_WIDTH-1:0] FULL    = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);
    localparam logic [ANGLE_WIDTH-1:0] QUARTER = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

    logic                   en;
    logic signed [COORD_WIDTH-1:0] pos [9];
    tpja_side_t             front_side_in;

    tpja_side_t             sq_side [ROOT_W+1];
    logic [RAD_W-1:0]       sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0]      sq_root [ROOT_W+1];
    logic [NORM_W-1:0]      sq_d    [ROOT_W+1];

    tpja_side_t             cd_side [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] cd_x    [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] cd_y    [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  cd_z    [CORDIC_STEPS+1];

    tpja_side_t             fin_side;
    logic signed [Z_W-1:0]  fin_z;
    logic [ZC_W-1:0]        zc;
    logic [ZC_W-1:0]        rnd;
    logic [ANGLE_WIDTH-1:0] quad;
    logic [ANGLE_WIDTH-1:0] angle_next;
    logic                   push;
    logic                   pop;

    logic                   out_valid_reg;
    logic [ANGLE_WIDTH-1:0] out_angle_reg;
    logic [TAG_WIDTH-1:0]   out_tag_reg;
    logic                   skid_valid_reg;
    logic [ANGLE_WIDTH-1:0] skid_angle_reg;
    logic [TAG_WIDTH-1:0]   skid_tag_reg;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    assign pos[0] = outer_x;
    assign pos[1] = outer_y;
    assign pos[2] = outer_z;
    assign pos[3] = vertex_x;
    assign pos[4] = vertex_y;
    assign pos[5] = vertex_z;
    assign pos[6] = inner_x;
    assign pos[7] = inner_y;
    assign pos[8] = inner_z;

    always_comb
    begin
        front_side_in       = '0;
        front_side_in.valid = in_valid;
        front_side_in.tag   = angle_tag;
    end

    tpja_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .pos      (pos),
        .side_in  (front_side_in),
        .rad      (sq_rem[0]),
        .dmag     (sq_d[0]),
        .side_out (sq_side[0])
    );

    assign sq_root[0] = '0;

    // square-root chain, most significant root bit first
    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        tpja_sqrt_cell #(
            .BIT (ROOT_W - 1 - j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (sq_side[j]),
            .rem_in   (sq_rem[j]),
            .root_in  (sq_root[j]),
            .d_in     (sq_d[j]),
            .side_out (sq_side[j+1]),
            .rem_out  (sq_rem[j+1]),
            .root_out (sq_root[j+1]),
            .d_out    (sq_d[j+1])
        );
    end

    always_comb
    begin
        cd_side[0]      = sq_side[ROOT_W];
        cd_side[0].coll = (sq_root[ROOT_W] == '0);
        cd_side[0].perp = (sq_d[ROOT_W] == '0);
    end

    assign cd_x[0] = XY_W'(sq_d[ROOT_W]);
    assign cd_y[0] = XY_W'(sq_root[ROOT_W]);
    assign cd_z[0] = '0;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        tpja_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (cd_side[i]),
            .x_in     (cd_x[i]),
            .y_in     (cd_y[i]),
            .z_in     (cd_z[i]),
            .side_out (cd_side[i+1]),
            .x_out    (cd_x[i+1]),
            .y_out    (cd_y[i+1]),
            .z_out    (cd_z[i+1])
        );
    end

    assign fin_side = cd_side[CORDIC_STEPS];
    assign fin_z    = cd_z[CORDIC_STEPS];

    always_comb
    begin
        priority if (fin_z < 0)
        begin
            zc = '0;
        end
        else if (fin_z > Z_W'(Z_MAX))
        begin
            zc = Z_MAX;
        end
        else
        begin
            zc = fin_z[ZC_W-1:0];
        end
    end

    assign rnd = zc + RND_HALF;

    always_comb
    begin
        priority if (fin_side.coll)
        begin
            quad = '0;
        end
        else if (fin_side.perp)
        begin
            quad = QUARTER;
        end
        else
        begin
            quad = ANGLE_WIDTH'(rnd >> SH);
        end
    end

    always_comb
    begin
        priority if (fin_side.zero)
        begin
            angle_next = FULL;
        end
        else if (fin_side.neg)
        begin
            angle_next = quad;
        end
        else
        begin
            angle_next = FULL - quad;
        end
    end

    assign push = en && fin_side.valid;
    assign pop  = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (out_valid_reg && !pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_angle_reg <= skid_angle_reg;
                out_tag_reg   <= skid_tag_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_angle_reg <= angle_next;
                skid_tag_reg   <= fin_side.tag;
            end
            else
            begin
                out_angle_reg <= angle_next;
                out_tag_reg   <= fin_side.tag;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign joint_angle = out_angle_reg;
    assign result_tag  = out_tag_reg;

endmodule
